### rtl/cstok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_pkg
// Shared types, token codes and the keyword lookup function of the tokenizer.
// ----------------------------------------------------------------------------
package cstok_pkg;

  // identifiers longer than this never match a keyword
  localparam int MAX_WORD_LEN  = 16;
  localparam int POSITION_BITS = 16;
  // longest keyword, and so the characters kept for matching
  localparam int KW_CHARS      = 9;
  localparam int MAX_RESULTS   = 3;

  typedef enum logic [6:0] {
    TK_END = 7'd0, TK_ERROR, TK_SEMI, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE,
    TK_LBRACK, TK_RBRACK, TK_ASSIGN, TK_EQ, TK_ARROW, TK_LT, TK_LE, TK_SHL,
    TK_SHL_ASSIGN, TK_GT, TK_GE, TK_SHR, TK_SHR_ASSIGN, TK_HASH, TK_AMP, TK_AND,
    TK_PLUS, TK_INC, TK_PLUS_ASSIGN, TK_MINUS, TK_DEC, TK_MINUS_ASSIGN, TK_STAR,
    TK_QUESTION, TK_OR, TK_XOR, TK_SLASH, TK_COLON, TK_COMMA, TK_NOT, TK_NE,
    TK_PIPE, TK_PERCENT, TK_DOT, TK_DOC, TK_STRING, TK_NUMBER, TK_BOOL_LIT,
    TK_IDENT, TK_KW_AS, TK_KW_DEFAULT, TK_TYPE_NAME, TK_KW_IF, TK_KW_ELSE,
    TK_KW_DO, TK_KW_WHILE, TK_KW_RETURN, TK_KW_IN, TK_KW_CONST, TK_KW_SWITCH,
    TK_KW_CASE, TK_KW_BREAK, TK_KW_CONTINUE, TK_KW_THROW, TK_KW_CATCH,
    TK_KW_FINALLY, TK_KW_TRY, TK_KW_VAR, TK_KW_USING, TK_KW_NAMESPACE,
    TK_KW_STATIC, TK_KW_VIRTUAL, TK_KW_READONLY, TK_KW_NEW, TK_KW_PUBLIC,
    TK_KW_PRIVATE, TK_KW_PROTECTED, TK_KW_INTERNAL, TK_KW_OVERRIDE,
    TK_KW_ABSTRACT, TK_KW_SEALED, TK_KW_ASYNC, TK_KW_AWAIT, TK_KW_GET,
    TK_KW_SET, TK_KW_THIS, TK_KW_VOID
  } token_kind_e;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic [30:0] integer_value;
    logic        is_float;
    logic        last_of_run;
  } tok_t;

  // tokens raised by one byte, oldest in entry 0
  typedef struct packed {
    logic [1:0]       n;
    tok_t [MAX_RESULTS-1:0] tok;
  } batch_t;

  // keyword bank: word holds the lower-cased characters, last one lowest
  function automatic logic [6:0] kw_kind(input logic [8*KW_CHARS-1:0] w);
    logic [6:0] k;
    case (w)
      "as":        k = TK_KW_AS;
      "true":      k = TK_BOOL_LIT;
      "false":     k = TK_BOOL_LIT;
      "default":   k = TK_KW_DEFAULT;
      "xor":       k = TK_XOR;
      "int":       k = TK_TYPE_NAME;
      "float":     k = TK_TYPE_NAME;
      "string":    k = TK_TYPE_NAME;
      "bool":      k = TK_TYPE_NAME;
      "char":      k = TK_TYPE_NAME;
      "struct":    k = TK_TYPE_NAME;
      "task":      k = TK_TYPE_NAME;
      "class":     k = TK_TYPE_NAME;
      "array":     k = TK_TYPE_NAME;
      "file":      k = TK_TYPE_NAME;
      "input":     k = TK_TYPE_NAME;
      "output":    k = TK_TYPE_NAME;
      "boolean":   k = TK_TYPE_NAME;
      "workflow":  k = TK_TYPE_NAME;
      "byte":      k = TK_TYPE_NAME;
      "short":     k = TK_TYPE_NAME;
      "long":      k = TK_TYPE_NAME;
      "object":    k = TK_TYPE_NAME;
      "map":       k = TK_TYPE_NAME;
      "pair":      k = TK_TYPE_NAME;
      "if":        k = TK_KW_IF;
      "else":      k = TK_KW_ELSE;
      "do":        k = TK_KW_DO;
      "while":     k = TK_KW_WHILE;
      "return":    k = TK_KW_RETURN;
      "in":        k = TK_KW_IN;
      "const":     k = TK_KW_CONST;
      "switch":    k = TK_KW_SWITCH;
      "case":      k = TK_KW_CASE;
      "break":     k = TK_KW_BREAK;
      "continue":  k = TK_KW_CONTINUE;
      "throw":     k = TK_KW_THROW;
      "catch":     k = TK_KW_CATCH;
      "finally":   k = TK_KW_FINALLY;
      "try":       k = TK_KW_TRY;
      "var":       k = TK_KW_VAR;
      "using":     k = TK_KW_USING;
      "namespace": k = TK_KW_NAMESPACE;
      "static":    k = TK_KW_STATIC;
      "virtual":   k = TK_KW_VIRTUAL;
      "readonly":  k = TK_KW_READONLY;
      "new":       k = TK_KW_NEW;
      "public":    k = TK_KW_PUBLIC;
      "private":   k = TK_KW_PRIVATE;
      "protected": k = TK_KW_PROTECTED;
      "internal":  k = TK_KW_INTERNAL;
      "override":  k = TK_KW_OVERRIDE;
      "abstract":  k = TK_KW_ABSTRACT;
      "sealed":    k = TK_KW_SEALED;
      "async":     k = TK_KW_ASYNC;
      "await":     k = TK_KW_AWAIT;
      "get":       k = TK_KW_GET;
      "set":       k = TK_KW_SET;
      "this":      k = TK_KW_THIS;
      "void":      k = TK_KW_VOID;
      default:     k = TK_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/cstok_src_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_src_if
// Source byte channel: one byte of text per beat.
// ----------------------------------------------------------------------------
interface cstok_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       end_of_source;

  modport source (output valid, source_char, end_of_source, input ready);
  modport sink (input valid, source_char, end_of_source, output ready);
endinterface

### rtl/cstok_tok_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_tok_if
// Token channel: one token per beat.
// ----------------------------------------------------------------------------
interface cstok_tok_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] lexeme_length;
  logic [30:0] integer_value;
  logic        is_float;
  logic        last_of_run;

  modport source (output valid, token_kind, start_line, start_column, lexeme_length,
                  integer_value, is_float, last_of_run, input ready);
  modport sink (input valid, token_kind, start_line, start_column, lexeme_length,
                integer_value, is_float, last_of_run, output ready);
endinterface

### rtl/cstok_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_lexer
// Scanner state and the per-byte decision logic; yields up to three tokens.
// ----------------------------------------------------------------------------
module cstok_lexer #(
  parameter int PositionBits = cstok_pkg::POSITION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          source_char_i,
  input  logic                end_of_source_i,
  output cstok_pkg::batch_t   batch_o
);

  localparam int KwBits = 8 * cstok_pkg::KW_CHARS;
  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);

  typedef enum logic [10:0] {
    M_IDLE   = 11'h001,
    M_IDENT  = 11'h002,
    M_NUMBER = 11'h004,
    M_STRING = 11'h008,
    M_OP     = 11'h010,
    M_SHIFT  = 11'h020,
    M_SLASH2 = 11'h040,
    M_LINE   = 11'h080,
    M_DOC    = 11'h100,
    M_BLOCK  = 11'h200,
    M_STAR   = 11'h400
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic [KwBits-1:0]       word_q, word_d;
  logic [15:0]             len_q, len_d;
  logic [31:0]             acc_q, acc_d;
  logic [1:0]              dots_q, dots_d;
  logic [7:0]              pend_q, pend_d;
  logic [7:0]              quote_q, quote_d;
  logic [PositionBits-1:0] line_q, line_d, col_q, col_d, tsl_q, tsl_d, tsc_q, tsc_d;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [PositionBits-1:0] pos_inc(input logic [PositionBits-1:0] v);
    return (v == '1) ? v : v + PosOne;
  endfunction

  function automatic logic [15:0] sat16(input logic [PositionBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] p);
    logic [6:0] k;
    case (p)
      "=":     k = cstok_pkg::TK_ASSIGN;
      "<":     k = cstok_pkg::TK_LT;
      ">":     k = cstok_pkg::TK_GT;
      "&":     k = cstok_pkg::TK_AMP;
      "+":     k = cstok_pkg::TK_PLUS;
      "-":     k = cstok_pkg::TK_MINUS;
      "!":     k = cstok_pkg::TK_NOT;
      "|":     k = cstok_pkg::TK_PIPE;
      "/":     k = cstok_pkg::TK_SLASH;
      default: k = cstok_pkg::TK_ERROR;
    endcase
    return k;
  endfunction

  // two-character operators; TK_END means no pair
  function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [6:0] k;
    k = cstok_pkg::TK_END;
    if (p == "=" && c == "=") k = cstok_pkg::TK_EQ;
    if (p == "=" && c == ">") k = cstok_pkg::TK_ARROW;
    if (p == "<" && c == "=") k = cstok_pkg::TK_LE;
    if (p == ">" && c == "=") k = cstok_pkg::TK_GE;
    if (p == "&" && c == "&") k = cstok_pkg::TK_AND;
    if (p == "+" && c == "+") k = cstok_pkg::TK_INC;
    if (p == "+" && c == "=") k = cstok_pkg::TK_PLUS_ASSIGN;
    if (p == "-" && c == "-") k = cstok_pkg::TK_DEC;
    if (p == "-" && c == "=") k = cstok_pkg::TK_MINUS_ASSIGN;
    if (p == "!" && c == "=") k = cstok_pkg::TK_NE;
    if (p == "|" && c == "|") k = cstok_pkg::TK_OR;
    return k;
  endfunction

  // one-character tokens raised directly from idle; TK_END means none
  function automatic logic [6:0] start_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      ";":     k = cstok_pkg::TK_SEMI;
      "(":     k = cstok_pkg::TK_LPAREN;
      ")":     k = cstok_pkg::TK_RPAREN;
      "{":     k = cstok_pkg::TK_LBRACE;
      "}":     k = cstok_pkg::TK_RBRACE;
      "[":     k = cstok_pkg::TK_LBRACK;
      "]":     k = cstok_pkg::TK_RBRACK;
      "#":     k = cstok_pkg::TK_HASH;
      "*":     k = cstok_pkg::TK_STAR;
      "?":     k = cstok_pkg::TK_QUESTION;
      "^":     k = cstok_pkg::TK_XOR;
      ":":     k = cstok_pkg::TK_COLON;
      ",":     k = cstok_pkg::TK_COMMA;
      "%":     k = cstok_pkg::TK_PERCENT;
      ".":     k = cstok_pkg::TK_DOT;
      default: k = cstok_pkg::TK_END;
    endcase
    return k;
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c == "=" || c == "<" || c == ">" || c == "&" || c == "+" || c == "-" ||
           c == "!" || c == "|" || c == "/";
  endfunction

  function automatic logic [6:0] word_kind(input logic [KwBits-1:0] w, input logic [15:0] n);
    logic [6:0] k;
    if (n > 16'(cstok_pkg::MAX_WORD_LEN) || n > 16'(cstok_pkg::KW_CHARS)) begin
      k = cstok_pkg::TK_IDENT;
    end else begin
      k = cstok_pkg::kw_kind(w);
    end
    return k;
  endfunction

  function automatic cstok_pkg::tok_t mk_tok(input logic [6:0] k,
                                             input logic [PositionBits-1:0] ln,
                                             input logic [PositionBits-1:0] cl,
                                             input logic [15:0] n,
                                             input logic [30:0] iv,
                                             input logic fl);
    cstok_pkg::tok_t t;
    t.token_kind    = k;
    t.start_line    = sat16(ln);
    t.start_column  = sat16(cl);
    t.lexeme_length = n;
    t.integer_value = iv;
    t.is_float      = fl;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  // per-byte scan: continue the open token, else start one, then flush on end
  always_comb begin
    mode_e                   m;
    logic [KwBits-1:0]       w;
    logic [15:0]             n;
    logic [31:0]             acc;
    logic [1:0]              dots;
    logic [7:0]              pend, qc, c;
    logic [PositionBits-1:0] ln, cl, tsl, tsc;
    logic [34:0]             v;
    logic [6:0]              k;
    logic [1:0]              cnt;
    logic                    taken;
    cstok_pkg::tok_t [cstok_pkg::MAX_RESULTS-1:0] res;

    m = mode_q; w = word_q; n = len_q; acc = acc_q; dots = dots_q;
    pend = pend_q; qc = quote_q; tsl = tsl_q; tsc = tsc_q;
    c = source_char_i;
    cnt = 2'd0;
    taken = 1'b0;
    res = '0;
    v = '0;
    k = cstok_pkg::TK_END;

    // position counters
    if (c == 8'h0A) begin
      ln = pos_inc(line_q);
      cl = '0;
    end else begin
      ln = line_q;
      cl = pos_inc(col_q);
    end

    // continue the token in progress
    case (m)
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_" || c == "?") begin
          if (n < 16'(cstok_pkg::KW_CHARS)) w = {w[KwBits-9:0], to_lower(c)};
          if (n != 16'hFFFF) n = n + 16'd1;
          if (c == "?") begin
            // a trailing '?' never forms a keyword
            res[cnt] = mk_tok(cstok_pkg::TK_IDENT, tsl, tsc, n, '0, 1'b0);
            cnt = cnt + 2'd1;
            m = M_IDLE;
          end
          taken = 1'b1;
        end else begin
          res[cnt] = mk_tok(word_kind(w, n), tsl, tsc, n, '0, 1'b0);
          cnt = cnt + 2'd1;
          m = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          if (!acc[31]) begin
            v = 35'({acc[30:0], 3'b000}) + 35'({acc[30:0], 1'b0}) + 35'(c[3:0]);
            acc = (v > 35'h0_7FFF_FFFF) ? 32'h8000_0000 : v[31:0];
          end
          if (n != 16'hFFFF) n = n + 16'd1;
          taken = 1'b1;
        end else if (c == ".") begin
          if (dots != 2'd2) dots = dots + 2'd1;
          if (n != 16'hFFFF) n = n + 16'd1;
          taken = 1'b1;
        end else begin
          if (dots == 2'd1) begin
            res[cnt] = mk_tok(cstok_pkg::TK_NUMBER, tsl, tsc, n, '0, 1'b1);
          end else if (dots == 2'd0 && !acc[31]) begin
            res[cnt] = mk_tok(cstok_pkg::TK_NUMBER, tsl, tsc, n, acc[30:0], 1'b0);
          end else begin
            res[cnt] = mk_tok(cstok_pkg::TK_ERROR, tsl, tsc, n, '0, 1'b0);
          end
          cnt = cnt + 2'd1;
          m = M_IDLE;
        end
      end
      M_STRING: begin
        if (c == qc) begin
          res[cnt] = mk_tok(cstok_pkg::TK_STRING, tsl, tsc, n, '0, 1'b0);
          cnt = cnt + 2'd1;
          m = M_IDLE;
        end else if (n != 16'hFFFF) begin
          n = n + 16'd1;
        end
        taken = 1'b1;
      end
      M_OP: begin
        if ((pend == "<" || pend == ">") && c == pend) begin
          m = M_SHIFT;
          taken = 1'b1;
        end else if (pend == "/" && c == "/") begin
          m = M_SLASH2;
          taken = 1'b1;
        end else if (pend == "/" && c == "*") begin
          m = M_BLOCK;
          taken = 1'b1;
        end else begin
          k = pair_kind(pend, c);
          m = M_IDLE;
          if (k != cstok_pkg::TK_END) begin
            res[cnt] = mk_tok(k, tsl, tsc, 16'd2, '0, 1'b0);
            taken = 1'b1;
          end else begin
            res[cnt] = mk_tok(single_kind(pend), tsl, tsc, 16'd1, '0, 1'b0);
          end
          cnt = cnt + 2'd1;
        end
      end
      M_SHIFT: begin
        m = M_IDLE;
        if (c == "=") begin
          k = (pend == "<") ? cstok_pkg::TK_SHL_ASSIGN : cstok_pkg::TK_SHR_ASSIGN;
          res[cnt] = mk_tok(k, tsl, tsc, 16'd3, '0, 1'b0);
          taken = 1'b1;
        end else begin
          k = (pend == "<") ? cstok_pkg::TK_SHL : cstok_pkg::TK_SHR;
          res[cnt] = mk_tok(k, tsl, tsc, 16'd2, '0, 1'b0);
        end
        cnt = cnt + 2'd1;
      end
      M_SLASH2: begin
        if (c == "/") begin
          m = M_DOC;
          n = 16'd3;
        end else begin
          m = (c == 8'h0A) ? M_IDLE : M_LINE;
        end
        taken = 1'b1;
      end
      M_LINE: begin
        if (c == 8'h0A) m = M_IDLE;
        taken = 1'b1;
      end
      M_DOC: begin
        if (c == 8'h0A) begin
          res[cnt] = mk_tok(cstok_pkg::TK_DOC, tsl, tsc, n, '0, 1'b0);
          cnt = cnt + 2'd1;
          m = M_IDLE;
        end else begin
          if (n != 16'hFFFF) n = n + 16'd1;
          taken = 1'b1;
        end
      end
      M_BLOCK: begin
        if (c == "*") m = M_STAR;
        taken = 1'b1;
      end
      M_STAR: begin
        if (c == "/") m = M_IDLE;
        else if (c != "*") m = M_BLOCK;
        taken = 1'b1;
      end
      default: begin
        m = M_IDLE;
      end
    endcase

    // start a new token
    if (!taken && !is_space(c)) begin
      tsl = ln;
      tsc = cl;
      k = start_kind(c);
      if (k != cstok_pkg::TK_END) begin
        res[cnt] = mk_tok(k, tsl, tsc, 16'd1, '0, 1'b0);
        cnt = cnt + 2'd1;
      end else if (is_alpha(c) || c == "_") begin
        w = {{(KwBits-8){1'b0}}, to_lower(c)};
        n = 16'd1;
        m = M_IDENT;
      end else if (is_digit(c)) begin
        acc = {28'd0, c[3:0]};
        dots = 2'd0;
        n = 16'd1;
        m = M_NUMBER;
      end else if (c == "\"" || c == "'") begin
        qc = c;
        n = 16'd0;
        m = M_STRING;
      end else if (is_op_start(c)) begin
        pend = c;
        m = M_OP;
      end else begin
        res[cnt] = mk_tok(cstok_pkg::TK_ERROR, tsl, tsc, 16'd1, '0, 1'b0);
        cnt = cnt + 2'd1;
      end
    end

    // end of source: flush, end token, back to reset values
    if (end_of_source_i) begin
      case (m)
        M_IDENT: begin
          res[cnt] = mk_tok(word_kind(w, n), tsl, tsc, n, '0, 1'b0);
          cnt = cnt + 2'd1;
        end
        M_NUMBER: begin
          if (dots == 2'd1) begin
            res[cnt] = mk_tok(cstok_pkg::TK_NUMBER, tsl, tsc, n, '0, 1'b1);
          end else if (dots == 2'd0 && !acc[31]) begin
            res[cnt] = mk_tok(cstok_pkg::TK_NUMBER, tsl, tsc, n, acc[30:0], 1'b0);
          end else begin
            res[cnt] = mk_tok(cstok_pkg::TK_ERROR, tsl, tsc, n, '0, 1'b0);
          end
          cnt = cnt + 2'd1;
        end
        M_STRING: begin
          res[cnt] = mk_tok(cstok_pkg::TK_STRING, tsl, tsc, n, '0, 1'b0);
          cnt = cnt + 2'd1;
        end
        M_OP: begin
          res[cnt] = mk_tok(single_kind(pend), tsl, tsc, 16'd1, '0, 1'b0);
          cnt = cnt + 2'd1;
        end
        M_SHIFT: begin
          k = (pend == "<") ? cstok_pkg::TK_SHL : cstok_pkg::TK_SHR;
          res[cnt] = mk_tok(k, tsl, tsc, 16'd2, '0, 1'b0);
          cnt = cnt + 2'd1;
        end
        M_DOC: begin
          res[cnt] = mk_tok(cstok_pkg::TK_DOC, tsl, tsc, n, '0, 1'b0);
          cnt = cnt + 2'd1;
        end
        default: begin
        end
      endcase
      res[cnt] = mk_tok(cstok_pkg::TK_END, ln, pos_inc(cl), 16'd0, '0, 1'b0);
      cnt = cnt + 2'd1;
      m = M_IDLE; n = '0; pend = '0; qc = '0; acc = '0; dots = '0;
      ln = PosOne; cl = '0; tsl = PosOne; tsc = '0;
    end

    if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;

    batch_o.n   = cnt;
    batch_o.tok = res;
    mode_d = m; word_d = w; len_d = n; acc_d = acc; dots_d = dots;
    pend_d = pend; quote_d = qc; line_d = ln; col_d = cl; tsl_d = tsl; tsc_d = tsc;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      len_q   <= '0;
      acc_q   <= '0;
      dots_q  <= '0;
      pend_q  <= '0;
      quote_q <= '0;
      line_q  <= PosOne;
      col_q   <= '0;
      tsl_q   <= PosOne;
      tsc_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      dots_q  <= dots_d;
      pend_q  <= pend_d;
      quote_q <= quote_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tsl_q   <= tsl_d;
      tsc_q   <= tsc_d;
    end
  end

  // word characters, valid only while an identifier is open
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      word_q <= word_d;
    end
  end

endmodule

### rtl/cstok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstok_fifo
// Four-entry token queue: takes up to three tokens a cycle, gives one a beat.
// ----------------------------------------------------------------------------
module cstok_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cstok_pkg::batch_t batch_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              pop_i,
  output cstok_pkg::tok_t   tok_o
);

  localparam int Depth = 4;

  cstok_pkg::tok_t  mem_q [Depth];
  logic [1:0]       wptr_q, rptr_q;
  logic [2:0]       count_q;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push  = push_i ? batch_i.n : 2'd0;
  assign pop     = pop_i && (count_q != 3'd0);
  assign valid_o = count_q != 3'd0;
  // room for a full batch of three
  assign room_o  = count_q <= 3'd1;
  assign tok_o   = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + n_push;
      rptr_q  <= rptr_q + {1'b0, pop};
      count_q <= count_q + {1'b0, n_push} - {2'b00, pop};
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < cstok_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < n_push) begin
        mem_q[wptr_q + 2'(i)] <= batch_i.tok[i];
      end
    end
  end

endmodule

### rtl/csharp_like_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csharp_like_tokenizer_unit
// Streaming tokenizer for a small C#-like language, one byte per beat.
// ----------------------------------------------------------------------------
// A token is queued with the byte that ends it and offered on tok_o in order.
// Throughput: one byte per cycle while each byte raises at most one token and
//   tok_o is ready; a byte raising two or three tokens holds the input until
//   the four-entry token queue, draining one token per beat, has room again.
// Reset: clears scanner mode and counters at once; no clearing pass.
module csharp_like_tokenizer_unit #(
  parameter int PositionBits = cstok_pkg::POSITION_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cstok_src_if.sink   src_i,
  cstok_tok_if.source tok_o
);

  cstok_pkg::batch_t batch;
  cstok_pkg::tok_t   head;
  logic              room;
  logic              accept;

  assign src_i.ready = room;
  assign accept      = src_i.valid && room;

  cstok_lexer #(
    .PositionBits(PositionBits)
  ) u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .source_char_i  (src_i.source_char),
    .end_of_source_i(src_i.end_of_source),
    .batch_o        (batch)
  );

  cstok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .batch_i(batch),
    .room_o (room),
    .valid_o(tok_o.valid),
    .pop_i  (tok_o.ready),
    .tok_o  (head)
  );

  // token beat fields
  assign tok_o.token_kind    = head.token_kind;
  assign tok_o.start_line    = head.start_line;
  assign tok_o.start_column  = head.start_column;
  assign tok_o.lexeme_length = head.lexeme_length;
  assign tok_o.integer_value = head.integer_value;
  assign tok_o.is_float      = head.is_float;
  assign tok_o.last_of_run   = head.last_of_run;

endmodule
